// ===== rtl/thermometer_scratchpad_decode_unit_assert.svh =====
// Assertion macros shared by the scratchpad decoder modules.
`ifndef THERMOMETER_SCRATCHPAD_DECODE_UNIT_ASSERT_SVH
`define THERMOMETER_SCRATCHPAD_DECODE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsd assertion failed");

// Next-cycle implication, disabled during reset.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsd assertion failed");

`endif

// ===== rtl/tsd_pkg.sv =====
// Shared types and constants of the scratchpad decoder.
`timescale 1ns / 1ps
package tsd_pkg;

    // Scratchpad frame: eight data bytes and one CRC byte
    localparam int FRAME_BYTES = 9;
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam int IDX_W       = $clog2(STORE_BYTES);
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);

    // Device family codes
    typedef enum logic [1:0] {
        FAMILY_NINE_BIT   = 2'd0,
        FAMILY_TWELVE_A   = 2'd1,
        FAMILY_TWELVE_B   = 2'd2,
        FAMILY_UNKNOWN    = 2'd3
    } family_t;

    // Completed frame handed from the collector to the converter
    typedef struct packed {
        logic       crc_ok;
        logic [7:0] temp_lsb;
        logic [7:0] temp_msb;
        logic [7:0] config_byte;
        logic [7:0] count_remain;
        logic [7:0] count_per_c;
    } frame_item_t;

endpackage

// ===== rtl/tsd_if.sv =====
// Stream and configuration interfaces of the scratchpad decoder.
`timescale 1ns / 1ps

interface tsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scratch_byte;
    logic       frame_start;

    modport source (output valid, output scratch_byte, output frame_start, input ready);
    modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

interface tsd_result_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic signed [15:0] raw_temperature;
    logic signed [15:0] celsius_tenths;
    logic signed [15:0] fahrenheit_tenths;

    modport source (output valid, output crc_ok, output raw_temperature,
                    output celsius_tenths, output fahrenheit_tenths, input ready);
    modport sink   (input valid, input crc_ok, input raw_temperature,
                    input celsius_tenths, input fahrenheit_tenths, output ready);
endinterface

interface tsd_cfg_if;
    logic                valid;
    logic                ready;
    tsd_pkg::family_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tsd_frame.sv =====
// Frame collector: byte position, running CRC-8, byte store, frame item register.
`timescale 1ns / 1ps
`include "thermometer_scratchpad_decode_unit_assert.svh"

module tsd_frame (
    input  logic                clk,
    input  logic                rst_n,
    tsd_byte_if.sink            scratch,
    output tsd_pkg::frame_item_t item,
    output logic                item_valid,
    input  logic                item_ready
);
    import tsd_pkg::*;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       store_reg [STORE_BYTES];
    frame_item_t      item_reg, item_next;
    logic             item_valid_reg, item_valid_next;

    logic             beat;
    logic             last_byte;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       crc_eff;

    // Reflected CRC-8, one byte LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // Accept a byte whenever the item slot is free or draining
    assign scratch.ready = !item_valid_reg || item_ready;
    assign beat          = scratch.valid && scratch.ready;

    // Start mark restarts position and CRC for this byte
    assign pos_eff   = scratch.frame_start ? '0 : pos_reg;
    assign crc_eff   = scratch.frame_start ? '0 : crc_reg;
    assign last_byte = (pos_eff >= POS_W'(STORE_BYTES));

    // Advance position, CRC and the frame item
    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        item_next       = item_reg;
        item_valid_next = item_valid_reg && !item_ready;
        if (beat)
        begin
            if (last_byte)
            begin
                pos_next               = '0;
                crc_next               = '0;
                item_valid_next        = 1'b1;
                item_next.crc_ok       = (crc_eff == scratch.scratch_byte);
                item_next.temp_lsb     = store_reg[0];
                item_next.temp_msb     = store_reg[1];
                item_next.config_byte  = store_reg[4];
                item_next.count_remain = store_reg[6];
                item_next.count_per_c  = store_reg[7];
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
                crc_next = crc8_byte(crc_eff, scratch.scratch_byte);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // Store data bytes and the item payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (beat && !last_byte)
        begin
            store_reg[pos_eff[IDX_W-1:0]] <= scratch.scratch_byte;
        end
    end

    assign item       = item_reg;
    assign item_valid = item_valid_reg;

    `TSD_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_W'(STORE_BYTES))
    `TSD_ASSERT_NEXT(a_ninth_gives_item, clk, rst_n, beat && last_byte, item_valid_reg && pos_reg == '0)
    `TSD_ASSERT_NEXT(a_item_holds, clk, rst_n, item_valid_reg && !item_ready, item_valid_reg && $stable(item_reg))

endmodule

// ===== rtl/tsd_convert.sv =====
// Converter: family register, temperature decode, held value and result register.
`timescale 1ns / 1ps
`include "thermometer_scratchpad_decode_unit_assert.svh"

module tsd_convert (
    input  logic                clk,
    input  logic                rst_n,
    tsd_cfg_if.sink             cfg,
    input  tsd_pkg::frame_item_t item,
    input  logic                item_valid,
    output logic                item_ready,
    tsd_result_if.source        result
);
    import tsd_pkg::*;

    localparam logic [7:0]  CPD_SIXTEEN = 8'h10;
    localparam logic [15:0] HIGH_MASK   = 16'hFFF0;
    localparam logic [15:0] COUNT_BIAS  = 16'd12;
    localparam logic [18:0] FAHR_OFFSET = 19'd320;

    // Resolution codes in bits 6:5 of the configuration byte
    typedef enum logic [1:0] {
        RES_9BIT  = 2'b00,
        RES_10BIT = 2'b01,
        RES_11BIT = 2'b10,
        RES_12BIT = 2'b11
    } res_t;

    family_t            family_reg;
    logic [15:0]        held_reg, held_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic signed [15:0] raw_reg, cel_reg, fahr_reg;

    logic               take;
    logic [15:0]        base;
    logic [15:0]        shifted;
    logic [15:0]        decoded;
    res_t               res;
    logic signed [18:0] ext;
    logic signed [18:0] times5;
    logic signed [19:0] times9;
    logic signed [18:0] cel_full;
    logic signed [19:0] fahr_div;
    logic [18:0]        fahr_sum;

    // Configuration is always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= FAMILY_UNKNOWN;
        end
        else if (cfg.valid)
        begin
            family_reg <= cfg.data;
        end
    end

    // Take an item when the result register is free or draining
    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;

    // Decode the new temperature from the frame bytes
    always_comb
    begin
        base    = {item.temp_msb, item.temp_lsb};
        shifted = base << 3;
        res     = res_t'(item.config_byte[6:5]);
        decoded = base;
        if (family_reg == FAMILY_NINE_BIT)
        begin
            decoded = shifted;
            if (item.count_per_c == CPD_SIXTEEN)
            begin
                decoded = (shifted & HIGH_MASK) + COUNT_BIAS - {8'd0, item.count_remain};
            end
        end
        else
        begin
            unique case (res)
                RES_9BIT:  decoded = base & ~16'd7;
                RES_10BIT: decoded = base & ~16'd3;
                RES_11BIT: decoded = base & ~16'd1;
                RES_12BIT: decoded = base;
                default:   decoded = base;
            endcase
        end
    end

    // Keep the old value on a CRC mismatch
    assign held_next = item.crc_ok ? decoded : held_reg;

    // Scale to tenths, dividing by eight toward zero
    assign ext      = 19'(signed'(held_next));
    assign times5   = (ext <<< 2) + ext;
    assign times9   = (20'(ext) <<< 3) + 20'(ext);
    assign cel_full = (times5 + (held_next[15] ? 19'sd7 : 19'sd0)) >>> 3;
    assign fahr_div = (times9 + (held_next[15] ? 20'sd7 : 20'sd0)) >>> 3;
    assign fahr_sum = fahr_div[18:0] + FAHR_OFFSET;

    assign out_valid_next = take || (out_valid_reg && !result.ready);

    // Hold control state and the temperature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                held_reg <= held_next;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ok_reg   <= item.crc_ok;
            raw_reg  <= signed'(held_next);
            cel_reg  <= cel_full[15:0];
            fahr_reg <= signed'(fahr_sum[15:0]);
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.crc_ok            = ok_reg;
    assign result.raw_temperature   = raw_reg;
    assign result.celsius_tenths    = cel_reg;
    assign result.fahrenheit_tenths = fahr_reg;

    `TSD_ASSERT_NEXT(a_bad_crc_keeps, clk, rst_n, take && !item.crc_ok, $stable(held_reg))
    `TSD_ASSERT_NEXT(a_result_matches_held, clk, rst_n, take, raw_reg == signed'(held_reg))
    `TSD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid_reg && !result.ready, out_valid_reg && $stable(raw_reg) && $stable(ok_reg))

endmodule

// ===== rtl/thermometer_scratchpad_decode_unit.sv =====
// Top level of the thermometer scratchpad decoder.
//
//  channel  | role   | beat
//  ---------+--------+-------------------------------------------------
//  scratch  | sink   | scratch_byte, frame_start: one scratchpad byte
//  result   | source | crc_ok, raw_temperature, celsius/fahrenheit tenths
//  cfg      | sink   | data: sensor family, always ready
//
// One byte is taken per cycle unless the frame item slot is held full; bytes one
// to eight only update the CRC and store. The ninth byte gives a result through the
// frame item register, then the result register.
// Reset clears position, CRC, held temperature, valids; family resets to unknown.
// A stalled result holds the frame item, which then holds the byte input.
`timescale 1ns / 1ps

module thermometer_scratchpad_decode_unit (
    input  logic         clk,
    input  logic         rst_n,
    tsd_byte_if.sink     scratch,
    tsd_result_if.source result,
    tsd_cfg_if.sink      cfg
);
    import tsd_pkg::*;

    frame_item_t item;
    logic        item_valid;
    logic        item_ready;

    tsd_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .scratch    (scratch),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    tsd_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .result     (result)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the thermometer scratchpad decoder.
`timescale 1ns / 1ps

module testbench;
    import tsd_pkg::*;

    // Scratchpad decode constants
    localparam logic [7:0]  CRC_POLY            = 8'h8C;
    localparam logic [7:0]  COUNT_PER_C_NOMINAL = 8'h10;
    localparam logic [15:0] WHOLE_DEGREE_MASK   = 16'hFFF0;
    localparam logic [15:0] COUNT_OFFSET        = 16'd12;
    localparam logic [7:0]  RES_MASK            = 8'h60;
    localparam logic [7:0]  RES_NINE            = 8'h00;
    localparam logic [7:0]  RES_TEN             = 8'h20;
    localparam logic [7:0]  RES_ELEVEN          = 8'h40;
    localparam int          FAHRENHEIT_OFFSET   = 320;

    // Run shape
    localparam int SEGMENTS           = 6;
    localparam int RANDOM_PER_SEGMENT = 290;
    localparam int SETTLE_CYCLES      = 8;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int MAX_REPORTS        = 10;

    localparam family_t SEGMENT_FAMILY [SEGMENTS] = '{
        FAMILY_NINE_BIT, FAMILY_UNKNOWN, FAMILY_TWELVE_A,
        FAMILY_TWELVE_B, FAMILY_NINE_BIT, FAMILY_UNKNOWN
    };

    typedef struct packed {
        logic [7:0] value;
        logic       start;
    } scratch_beat_t;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] raw_temperature;
        logic [15:0] celsius_tenths;
        logic [15:0] fahrenheit_tenths;
    } reading_t;

    logic clk;
    logic rst_n;

    tsd_byte_if   scratch_bus ();
    tsd_result_if result_bus ();
    tsd_cfg_if    cfg_bus ();

    thermometer_scratchpad_decode_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .scratch(scratch_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Stimulus and scoreboard state
    scratch_beat_t pending_bytes [$];
    reading_t      readings_due [$];
    int            bytes_queued;
    int            bytes_accepted;
    int            error_count;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            cycle_count;
    logic          byte_taken;

    // Decoder state as predicted
    family_t       family_now;
    logic [3:0]    position_now;
    logic [7:0]    crc_now;
    logic [7:0]    frame_store [STORE_BYTES];
    logic [15:0]   held_now;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Dallas CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic [7:0] d;
        logic       mix;
        acc = crc;
        d   = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = acc[0] ^ d[0];
            acc = acc >> 1;
            if (mix)
                acc = acc ^ CRC_POLY;
            d = d >> 1;
        end
        return acc;
    endfunction

    // Form the new temperature from the stored bytes
    function automatic logic [15:0] decode_temperature();
        logic [15:0] t;
        t = {frame_store[1], frame_store[0]};
        if (family_now == FAMILY_NINE_BIT)
        begin
            t = t << 3;
            if (frame_store[7] == COUNT_PER_C_NOMINAL)
                t = (t & WHOLE_DEGREE_MASK) + COUNT_OFFSET - {8'h00, frame_store[6]};
        end
        else
        begin
            case (frame_store[4] & RES_MASK)
                RES_NINE:   t[2:0] = 3'b000;
                RES_TEN:    t[1:0] = 2'b00;
                RES_ELEVEN: t[0]   = 1'b0;
                default:    ;
            endcase
        end
        return t;
    endfunction

    // Advance the predicted state by one accepted byte
    task automatic absorb_byte(input logic [7:0] value, input logic start);
        reading_t next;
        int       raw;
        int       cel;
        int       fah;
        logic     ok;
        if (start)
        begin
            position_now = '0;
            crc_now      = '0;
        end
        if (position_now < STORE_BYTES)
        begin
            frame_store[position_now[2:0]] = value;
            crc_now      = crc8_step(crc_now, value);
            position_now = position_now + 4'd1;
        end
        else
        begin
            ok = (crc_now == value);
            if (ok)
                held_now = decode_temperature();
            position_now = '0;
            crc_now      = '0;
            raw = 32'($signed(held_now));
            cel = (raw * 5) / 8;
            fah = (raw * 9) / 8 + FAHRENHEIT_OFFSET;
            next.crc_ok            = ok;
            next.raw_temperature   = held_now;
            next.celsius_tenths    = cel[15:0];
            next.fahrenheit_tenths = fah[15:0];
            readings_due.insert(readings_due.size(), next);
        end
    endtask

    task automatic report_failure(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sample handshakes, predict and check
    always @(posedge clk)
    begin : monitor
        reading_t want;
        byte_taken = scratch_bus.valid && scratch_bus.ready;
        if (result_bus.valid && result_bus.ready)
        begin
            if (readings_due.size() == 0)
                report_failure($sformatf("result beat with none expected: ok=%0b raw=%h",
                               result_bus.crc_ok, result_bus.raw_temperature));
            else
            begin
                want = readings_due.pop_front();
                if (result_bus.crc_ok !== want.crc_ok)
                    report_failure($sformatf("crc_ok exp %0b got %0b",
                                   want.crc_ok, result_bus.crc_ok));
                if (result_bus.raw_temperature !== want.raw_temperature)
                    report_failure($sformatf("raw_temperature exp %h got %h",
                                   want.raw_temperature, result_bus.raw_temperature));
                if (result_bus.celsius_tenths !== want.celsius_tenths)
                    report_failure($sformatf("celsius_tenths exp %h got %h",
                                   want.celsius_tenths, result_bus.celsius_tenths));
                if (result_bus.fahrenheit_tenths !== want.fahrenheit_tenths)
                    report_failure($sformatf("fahrenheit_tenths exp %h got %h",
                                   want.fahrenheit_tenths, result_bus.fahrenheit_tenths));
            end
        end
        if (cfg_bus.valid && cfg_bus.ready)
            family_now = cfg_bus.data;
        if (byte_taken)
        begin
            absorb_byte(scratch_bus.scratch_byte, scratch_bus.frame_start);
            bytes_accepted++;
        end
    end

    // Drive the next scratchpad beat once the current one is taken
    always @(negedge clk)
    begin : driver
        scratch_beat_t beat;
        if (rst_n && (!scratch_bus.valid || byte_taken))
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                beat = pending_bytes.pop_front();
                scratch_bus.valid        <= 1'b1;
                scratch_bus.scratch_byte <= beat.value;
                scratch_bus.frame_start  <= beat.start;
            end
            else
                scratch_bus.valid <= 1'b0;
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        if (rst_n)
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic push_beat(input logic [7:0] value, input logic start);
        scratch_beat_t beat;
        beat.value = value;
        beat.start = start;
        pending_bytes.insert(pending_bytes.size(), beat);
        bytes_queued++;
    endtask

    // Queue eight data bytes and a CRC byte, optionally corrupted
    task automatic queue_frame(input logic [63:0] body, input bit with_start, input bit corrupt);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            push_beat(body[8*i +: 8], with_start && i == 0);
            crc = crc8_step(crc, body[8*i +: 8]);
        end
        if (corrupt)
            crc = crc ^ 8'($urandom_range(1, 255));
        push_beat(crc, 1'b0);
    endtask

    function automatic logic [63:0] random_body();
        logic [63:0] body;
        body = {$urandom, $urandom};
        if ($urandom_range(1))
            body[55:48] = 8'($urandom_range(0, 16));
        if ($urandom_range(9) < 6)
            body[63:56] = COUNT_PER_C_NOMINAL;
        return body;
    endfunction

    // Short partial frame, restart mid-frame with extremes, unmarked bad frame
    task automatic queue_directed();
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b0);
        queue_frame({8'h10, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b1, 1'b0);
        queue_frame({8'h10, 8'h00, 8'h0C, 8'h1F, 8'h4B, 8'h46, 8'h80, 8'h00}, 1'b0, 1'b1);
    endtask

    // Largest and smallest raw readings under the current family
    task automatic queue_extremes();
        logic [63:0] body;
        body = random_body();
        body[15:0] = 16'h7FFF;
        queue_frame(body, 1'b1, 1'b0);
        body = random_body();
        body[15:0] = 16'h8000;
        queue_frame(body, 1'b1, 1'b0);
    endtask

    // Mostly well-formed frames, some bad CRCs, truncated frames and noise
    task automatic queue_random(input int count);
        int first;
        int pick;
        int cut;
        first = bytes_queued;
        while (bytes_queued - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                queue_frame(random_body(), $urandom_range(9) < 8, 1'b0);
            else if (pick < 85)
                queue_frame(random_body(), 1'($urandom_range(1)), 1'b1);
            else if (pick < 95)
            begin
                cut = $urandom_range(1, STORE_BYTES);
                for (int i = 0; i < cut; i++)
                    push_beat(8'($urandom), i == 0);
            end
            else
                push_beat(8'($urandom), 1'($urandom));
        end
    endtask

    // Hold the sender until every result is in, then let the pipe drain
    task automatic settle();
        while (!(bytes_accepted == bytes_queued && readings_due.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_family(input family_t fam);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= fam;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Reset, then run the segments
    initial
    begin
        rst_n                    = 1'b0;
        scratch_bus.valid        = 1'b0;
        scratch_bus.scratch_byte = '0;
        scratch_bus.frame_start  = 1'b0;
        result_bus.ready         = 1'b0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.data             = FAMILY_UNKNOWN;
        family_now               = FAMILY_UNKNOWN;
        position_now             = '0;
        crc_now                  = '0;
        held_now                 = '0;
        byte_taken               = 1'b0;
        bytes_queued             = 0;
        bytes_accepted           = 0;
        error_count              = 0;
        sender_idle_pct          = 0;
        receiver_stall_pct       = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            frame_store[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            sender_idle_pct    = (seg < 2) ? 13 : (seg < 4) ? 83 : 0;
            receiver_stall_pct = (seg < 2) ? 83 : (seg < 4) ? 13 : 0;
            write_family(SEGMENT_FAMILY[seg]);
            if (seg == 0)
                queue_directed();
            queue_extremes();
            queue_random(RANDOM_PER_SEGMENT);
            settle();
        end

        if (readings_due.size() != 0)
            report_failure($sformatf("%0d results never arrived", readings_due.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
